/* rtl/vgbm_pkg.sv */
// Package: constants and types shared by the voxel greedy box merge block.
package vgbm_pkg;
   localparam int GRID_DIM_DEF  = 16;
   localparam int MAX_BOXES_DEF = 2048;
   localparam int COORD_W       = 4;
   localparam int ROW_IDX_W     = 8;
   localparam int ROW_BITS_W    = 16;
   localparam int BOXNUM_W      = 11;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_NEXT = 1'b1;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_CLEAR  = 11'b00000000010,
      ST_SCAN   = 11'b00000000100,
      ST_SCANW  = 11'b00000001000,
      ST_YRD    = 11'b00000010000,
      ST_YCHK   = 11'b00000100000,
      ST_ZRD    = 11'b00001000000,
      ST_ZCHK   = 11'b00010000000,
      ST_CLAIM  = 11'b00100000000,
      ST_CLAIMW = 11'b01000000000,
      ST_OUT    = 11'b10000000000
   } state_type;
endpackage

/* rtl/vgbm_row_mem.sv */
// Row memory: occupancy and claimed maps, one write port each and one shared read address.
module vgbm_row_mem #(
   parameter int GRID_DIM = vgbm_pkg::GRID_DIM_DEF,
   parameter int AW = $clog2(GRID_DIM * GRID_DIM)
) (
   input  logic                clock,
   input  logic                occ_we,
   input  logic [AW-1:0]       occ_waddr,
   input  logic [GRID_DIM-1:0] occ_wdata,
   input  logic                clm_we,
   input  logic [AW-1:0]       clm_waddr,
   input  logic [GRID_DIM-1:0] clm_wdata,
   input  logic [AW-1:0]       raddr,
   output logic [GRID_DIM-1:0] occ_rdata,
   output logic [GRID_DIM-1:0] clm_rdata
);
   localparam int ROWS = GRID_DIM * GRID_DIM;
   logic [GRID_DIM-1:0] occ_mem [ROWS];
   logic [GRID_DIM-1:0] clm_mem [ROWS];

   always_ff @(posedge clock) begin
      if (occ_we) begin
         occ_mem[occ_waddr] <= occ_wdata;
      end
      if (clm_we) begin
         clm_mem[clm_waddr] <= clm_wdata;
      end
      occ_rdata <= occ_mem[raddr];
      clm_rdata <= clm_mem[raddr];
   end
endmodule

/* rtl/voxel_greedy_box_merge.sv */
// Top level of the voxel greedy box merge block.
// A row load (req_type 0) writes one occupancy row and returns nothing.
// A box request (req_type 1) returns one transfer. After any load, the first request
// first sweeps the claimed map clear, one row a cycle; the occupancy map is cleared
// the same way after reset before the first item is taken. A request then scans
// row by row through the memory, grows the box along x inside the found row,
// reads one row per y step and one row per y of each z slab, and writes the
// claim back one row at a time (read, then write). Cost is data dependent; the
// single shared read address of the row memory serialises every read.
module voxel_greedy_box_merge #(
   parameter int GRID_DIM  = vgbm_pkg::GRID_DIM_DEF,
   parameter int MAX_BOXES = vgbm_pkg::MAX_BOXES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic [vgbm_pkg::ROW_IDX_W-1:0]    req_row_index,
   input  logic [vgbm_pkg::ROW_BITS_W-1:0]   req_row_bits,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_box_valid,
   output logic [vgbm_pkg::COORD_W-1:0]      rsp_lo_x,
   output logic [vgbm_pkg::COORD_W-1:0]      rsp_lo_y,
   output logic [vgbm_pkg::COORD_W-1:0]      rsp_lo_z,
   output logic [vgbm_pkg::COORD_W-1:0]      rsp_hi_x,
   output logic [vgbm_pkg::COORD_W-1:0]      rsp_hi_y,
   output logic [vgbm_pkg::COORD_W-1:0]      rsp_hi_z,
   output logic [vgbm_pkg::BOXNUM_W-1:0]     rsp_box_number
);
   import vgbm_pkg::*;

   localparam int CW   = $clog2(GRID_DIM);
   localparam int AW   = 2 * CW;
   localparam int ROWS = GRID_DIM * GRID_DIM;
   localparam int NW   = $clog2(MAX_BOXES + 1);

   state_type state_ff, state_in;

   // clear sweep
   logic [AW-1:0] clr_ff, clr_in;
   logic          occ_clr_ff, occ_clr_in;
   logic          restart_ff, restart_in;
   logic          done_ff, done_in;            // scan exhausted for this build
   logic [NW-1:0] nbox_ff, nbox_in;

   // scan position: row and x where the scan resumes
   logic [CW-1:0] cy_ff, cy_in, cz_ff, cz_in, cx_ff, cx_in;
   // box
   logic [CW-1:0] x0_ff, x0_in, x1_ff, x1_in, y0_ff, y0_in, y1_ff, y1_in;
   logic [CW-1:0] z0_ff, z0_in, z1_ff, z1_in, yi_ff, yi_in, zi_ff, zi_in;
   logic [GRID_DIM-1:0] m_ff, m_in;

   // output register
   logic          ov_ff, ov_in, obv_ff, obv_in;
   logic [COORD_W-1:0] olx_ff, olx_in, oly_ff, oly_in, olz_ff, olz_in;
   logic [COORD_W-1:0] ohx_ff, ohx_in, ohy_ff, ohy_in, ohz_ff, ohz_in;
   logic [BOXNUM_W-1:0] onum_ff, onum_in;

   // memory ports
   logic                occ_we, clm_we;
   logic [AW-1:0]       occ_waddr, clm_waddr, raddr;
   logic [GRID_DIM-1:0] occ_wdata, clm_wdata, occ_rdata, clm_rdata, free_row;

   vgbm_row_mem #(.GRID_DIM(GRID_DIM), .AW(AW)) u_mem (
      .clock, .occ_we, .occ_waddr, .occ_wdata, .clm_we, .clm_waddr, .clm_wdata,
      .raddr, .occ_rdata, .clm_rdata
   );

   assign free_row = occ_rdata & ~clm_rdata;

   logic acc_req, acc_rsp;
   assign req_ready = (state_ff == ST_IDLE) && !occ_clr_ff && !ov_ff;
   assign acc_req   = req_valid && req_ready;
   assign acc_rsp   = ov_ff && rsp_ready;

   // first free bit at or above cx, and the end of the free run from it
   logic                found;
   logic [CW-1:0]       fx;
   logic [GRID_DIM-1:0] above;
   logic [CW-1:0]       run_end;
   logic                run_stop;
   logic [GRID_DIM-1:0] xmask;

   always_comb begin
      found = 1'b0;
      fx    = '0;
      for (int i = GRID_DIM - 1; i >= 0; i--) begin
         above[i] = (CW'(i) >= cx_ff);
         if (free_row[i] && above[i]) begin
            found = 1'b1;
            fx    = CW'(i);
         end
      end
      // extend run from fx along x
      run_end  = fx;
      run_stop = 1'b0;
      for (int i = 0; i < GRID_DIM; i++) begin
         if (CW'(i) > fx && !run_stop) begin
            if (free_row[i]) begin
               run_end = CW'(i);
            end else begin
               run_stop = 1'b1;
            end
         end
      end
      xmask = '0;
      for (int i = 0; i < GRID_DIM; i++) begin
         xmask[i] = (CW'(i) >= fx) && (CW'(i) <= run_end);
      end
   end

   logic span_ok;
   assign span_ok = ((free_row & m_ff) == m_ff);

   localparam logic [CW-1:0] CMAX = CW'(GRID_DIM - 1);

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      occ_clr_in = occ_clr_ff;
      restart_in = restart_ff;
      done_in    = done_ff;
      nbox_in    = nbox_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff;
      x0_in = x0_ff; x1_in = x1_ff; y0_in = y0_ff; y1_in = y1_ff;
      z0_in = z0_ff; z1_in = z1_ff; yi_in = yi_ff; zi_in = zi_ff;
      m_in  = m_ff;
      ov_in = ov_ff; obv_in = obv_ff;
      olx_in = olx_ff; oly_in = oly_ff; olz_in = olz_ff;
      ohx_in = ohx_ff; ohy_in = ohy_ff; ohz_in = ohz_ff; onum_in = onum_ff;
      occ_we = 1'b0; occ_waddr = clr_ff; occ_wdata = '0;
      clm_we = 1'b0; clm_waddr = clr_ff; clm_wdata = '0;
      raddr  = {cz_ff, cy_ff};

      if (acc_rsp) begin
         ov_in = 1'b0;
      end

      // power-up sweep of the occupancy map
      if (occ_clr_ff) begin
         occ_we = 1'b1;
         clr_in = clr_ff + AW'(1);
         if (clr_ff == AW'(ROWS - 1)) begin
            occ_clr_in = 1'b0;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (acc_req) begin
               if (req_type == REQ_LOAD) begin
                  occ_we    = (req_row_index < ROW_IDX_W'(ROWS)) || (ROWS > 255);
                  occ_waddr = AW'(req_row_index);
                  occ_wdata = GRID_DIM'(req_row_bits);
                  restart_in = 1'b1;
               end else if (restart_ff) begin
                  restart_in = 1'b0;
                  clr_in     = '0;
                  cx_in = '0; cy_in = '0; cz_in = '0;
                  done_in = 1'b0;
                  nbox_in = '0;
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_CLEAR: begin
            clm_we = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(ROWS - 1)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // read issued at {cz,cy}
            if (done_ff || nbox_ff >= NW'(MAX_BOXES)) begin
               obv_in = 1'b0;
               state_in = ST_OUT;
            end else begin
               state_in = ST_SCANW;
            end
         end
         ST_SCANW: begin
            if (found) begin
               x0_in = fx; x1_in = run_end; m_in = xmask;
               y0_in = cy_ff; y1_in = cy_ff; z0_in = cz_ff; z1_in = cz_ff;
               // resume just past the found voxel
               if (fx == CMAX) begin
                  cx_in = '0;
                  if (cy_ff == CMAX) begin
                     cy_in = '0;
                     if (cz_ff == CMAX) begin
                        done_in = 1'b1;
                     end else begin
                        cz_in = cz_ff + CW'(1);
                     end
                  end else begin
                     cy_in = cy_ff + CW'(1);
                  end
               end else begin
                  cx_in = fx + CW'(1);
               end
               state_in = (cy_ff == CMAX) ? ST_ZRD : ST_YRD;
               yi_in = cy_ff;
            end else begin
               cx_in = '0;
               if (cy_ff == CMAX) begin
                  cy_in = '0;
                  if (cz_ff == CMAX) begin
                     done_in  = 1'b1;
                     obv_in   = 1'b0;
                     state_in = ST_OUT;
                  end else begin
                     cz_in = cz_ff + CW'(1);
                     state_in = ST_SCAN;
                  end
               end else begin
                  cy_in = cy_ff + CW'(1);
                  state_in = ST_SCAN;
               end
            end
         end
         ST_YRD: begin
            raddr = {z0_ff, y1_ff + CW'(1)};
            state_in = ST_YCHK;
         end
         ST_YCHK: begin
            if (span_ok) begin
               y1_in = y1_ff + CW'(1);
               state_in = (y1_ff + CW'(1) == CMAX) ? ST_ZRD : ST_YRD;
            end else begin
               state_in = ST_ZRD;
            end
            yi_in = y0_ff;
         end
         ST_ZRD: begin
            if (z1_ff == CMAX) begin
               zi_in = z0_ff; yi_in = y0_ff;
               state_in = ST_CLAIM;
            end else begin
               raddr = {z1_ff + CW'(1), yi_ff};
               state_in = ST_ZCHK;
            end
         end
         ST_ZCHK: begin
            if (!span_ok) begin
               zi_in = z0_ff; yi_in = y0_ff;
               state_in = ST_CLAIM;
            end else if (yi_ff == y1_ff) begin
               z1_in = z1_ff + CW'(1);
               yi_in = y0_ff;
               state_in = ST_ZRD;
            end else begin
               yi_in = yi_ff + CW'(1);
               state_in = ST_ZRD;
            end
         end
         ST_CLAIM: begin
            raddr = {zi_ff, yi_ff};
            state_in = ST_CLAIMW;
         end
         ST_CLAIMW: begin
            clm_we    = 1'b1;
            clm_waddr = {zi_ff, yi_ff};
            clm_wdata = clm_rdata | m_ff;
            if (yi_ff == y1_ff) begin
               yi_in = y0_ff;
               if (zi_ff == z1_ff) begin
                  obv_in = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  zi_in = zi_ff + CW'(1);
                  state_in = ST_CLAIM;
               end
            end else begin
               yi_in = yi_ff + CW'(1);
               state_in = ST_CLAIM;
            end
         end
         ST_OUT: begin
            // load the output register; drop fields for an empty answer
            ov_in = 1'b1;
            if (obv_ff) begin
               olx_in = COORD_W'(x0_ff); oly_in = COORD_W'(y0_ff);
               olz_in = COORD_W'(z0_ff); ohx_in = COORD_W'(x1_ff);
               ohy_in = COORD_W'(y1_ff); ohz_in = COORD_W'(z1_ff);
               onum_in = BOXNUM_W'(nbox_ff);
               nbox_in = nbox_ff + NW'(1);
            end else begin
               olx_in = '0; oly_in = '0; olz_in = '0;
               ohx_in = '0; ohy_in = '0; ohz_in = '0; onum_in = '0;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         clr_ff     <= '0;
         occ_clr_ff <= 1'b1;
         restart_ff <= 1'b1;
         done_ff    <= 1'b0;
         nbox_ff    <= '0;
         ov_ff      <= 1'b0;
         cx_ff <= '0; cy_ff <= '0; cz_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         occ_clr_ff <= occ_clr_in;
         restart_ff <= restart_in;
         done_ff    <= done_in;
         nbox_ff    <= nbox_in;
         ov_ff      <= ov_in;
         cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff <= x0_in; x1_ff <= x1_in; y0_ff <= y0_in; y1_ff <= y1_in;
      z0_ff <= z0_in; z1_ff <= z1_in; yi_ff <= yi_in; zi_ff <= zi_in;
      m_ff  <= m_in;  obv_ff <= obv_in;
      olx_ff <= olx_in; oly_ff <= oly_in; olz_ff <= olz_in;
      ohx_ff <= ohx_in; ohy_ff <= ohy_in; ohz_ff <= ohz_in; onum_ff <= onum_in;
   end

   assign rsp_valid      = ov_ff;
   assign rsp_box_valid  = obv_ff;
   assign rsp_lo_x       = olx_ff;
   assign rsp_lo_y       = oly_ff;
   assign rsp_lo_z       = olz_ff;
   assign rsp_hi_x       = ohx_ff;
   assign rsp_hi_y       = ohy_ff;
   assign rsp_hi_z       = ohz_ff;
   assign rsp_box_number = onum_ff;
endmodule
